/* rtl/phc_pkg.sv */
// ----------------------------------------------------------------------------
// phc_pkg
// Shared widths, instruction kind codes, counter indexes and channel payloads
// of the pipeline hazard counter.
// ----------------------------------------------------------------------------
package phc_pkg;

  localparam int HISTORY_DEPTH = 4;   // 4..16; distances 1 to 3 are compared
  localparam int REG_W         = 5;
  localparam int KIND_W        = 2;
  localparam int CNT_W         = 32;
  localparam int NUM_COUNTERS  = 11;
  localparam int CIDX_W        = $clog2(NUM_COUNTERS);

  // instruction kinds
  localparam logic [KIND_W-1:0] KIND_R    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_I    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_J    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD = 2'd3;

  // counter slots, in result order
  localparam logic [CIDX_W-1:0] C_RAW5    = 4'd0;
  localparam logic [CIDX_W-1:0] C_LU5     = 4'd1;
  localparam logic [CIDX_W-1:0] C_WAW5    = 4'd2;
  localparam logic [CIDX_W-1:0] C_RAW7N   = 4'd3;
  localparam logic [CIDX_W-1:0] C_RAW7F   = 4'd4;
  localparam logic [CIDX_W-1:0] C_LU7N    = 4'd5;
  localparam logic [CIDX_W-1:0] C_LU7F    = 4'd6;
  localparam logic [CIDX_W-1:0] C_WAW7    = 4'd7;
  localparam logic [CIDX_W-1:0] C_RAW13D1 = 4'd8;
  localparam logic [CIDX_W-1:0] C_RAW13D2 = 4'd9;
  localparam logic [CIDX_W-1:0] C_RAW13D3 = 4'd10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  src_reg_a;
    logic [REG_W-1:0]  src_reg_b;
  } instr_t;

  typedef struct packed {
    logic [CNT_W-1:0] raw_5stage;
    logic [CNT_W-1:0] loaduse_5stage;
    logic [CNT_W-1:0] waw_5stage;
    logic [CNT_W-1:0] raw_7stage_near;
    logic [CNT_W-1:0] raw_7stage_far;
    logic [CNT_W-1:0] loaduse_7stage_near;
    logic [CNT_W-1:0] loaduse_7stage_far;
    logic [CNT_W-1:0] waw_7stage;
    logic [CNT_W-1:0] raw_13stage_d1;
    logic [CNT_W-1:0] raw_13stage_d2;
    logic [CNT_W-1:0] raw_13stage_d3;
  } counts_t;

endpackage

/* rtl/phc_if.sv */
// ----------------------------------------------------------------------------
// phc_if
// Valid/ready channels of the pipeline hazard counter: instruction input and
// counter snapshot output.
// ----------------------------------------------------------------------------
interface phc_in_if import phc_pkg::*; ();
  logic   valid;
  logic   ready;
  instr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface phc_out_if import phc_pkg::*; ();
  logic    valid;
  logic    ready;
  counts_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pipeline_hazard_counter.sv */
// ----------------------------------------------------------------------------
// pipeline_hazard_counter
// Counts RAW, load-use and WAW data hazards of a decoded instruction stream
// for 5-, 7- and 13-stage pipelines; emits all eleven counters per item.
// ----------------------------------------------------------------------------
//  channel   dir   payload    transfer when
//  instr     in    instr_t    instr.valid && instr.ready
//  counts    out   counts_t   counts.valid && counts.ready
//
//  One instruction per cycle while the output does not stall; from instr
//  transfer to counts valid: decode register, then compare and count.
//  The counters themselves are the result register; they move only when the
//  previous snapshot has been taken, and the decode register absorbs one
//  more instruction while the output stalls.
//  Synchronous reset clears history, counters and valid flags.
// ----------------------------------------------------------------------------
module pipeline_hazard_counter import phc_pkg::*; (
  input logic      clk,
  input logic      rst,
  phc_in_if.sink   instr,
  phc_out_if.source counts
);

  // decoded instruction register
  logic             s1_valid;
  logic [REG_W-1:0] s1_w, s1_a, s1_b, s1_ld;
  logic [REG_W-1:0] w_next, a_next, b_next, ld_next;

  // history, entry 0 is the newest committed instruction (distance 1)
  logic [HISTORY_DEPTH-1:0][REG_W-1:0] dest_hist, src_a_hist, src_b_hist, load_hist;

  logic [NUM_COUNTERS-1:0][CNT_W-1:0] cnt;
  logic [NUM_COUNTERS-1:0]            inc;
  logic                               out_valid;

  logic adv;
  logic raw1, raw2, raw3, lu1, lu2, waw1, waw2;

  assign adv         = s1_valid && (!out_valid || counts.ready);
  assign instr.ready = !s1_valid || adv;

  always_comb begin
    w_next  = '0;
    a_next  = '0;
    b_next  = '0;
    ld_next = '0;
    unique case (instr.data.kind)
      KIND_R: begin
        w_next = instr.data.dest_reg;
        a_next = instr.data.src_reg_a;
        b_next = instr.data.src_reg_b;
      end
      KIND_I: begin
        w_next = instr.data.src_reg_b;
        a_next = instr.data.src_reg_a;
      end
      KIND_LOAD: begin
        w_next  = instr.data.src_reg_b;
        a_next  = instr.data.src_reg_a;
        ld_next = instr.data.src_reg_b;
      end
      default: ;  // J-type touches no registers
    endcase
  end

  function automatic logic src_hit(input logic [REG_W-1:0] a, input logic [REG_W-1:0] b,
                                   input logic [REG_W-1:0] h);
    src_hit = ((a != '0) && (a == h)) || ((b != '0) && (b == h));
  endfunction

  // register 0 never matches
  assign raw1 = src_hit(s1_a, s1_b, dest_hist[0]);
  assign raw2 = src_hit(s1_a, s1_b, dest_hist[1]);
  assign raw3 = src_hit(s1_a, s1_b, dest_hist[2]);
  assign lu1  = src_hit(s1_a, s1_b, load_hist[0]);
  assign lu2  = src_hit(s1_a, s1_b, load_hist[1]);
  assign waw1 = (s1_w != '0) && (s1_w == dest_hist[0]);
  assign waw2 = (s1_w != '0) && (s1_w == dest_hist[1]);

  always_comb begin
    inc            = '0;
    inc[C_RAW5]    = raw1;
    inc[C_LU5]     = lu1;
    inc[C_WAW5]    = waw1;
    inc[C_RAW7N]   = raw1;
    inc[C_RAW7F]   = !raw1 && raw2;
    inc[C_LU7N]    = lu1;
    inc[C_LU7F]    = !lu1 && lu2;
    inc[C_WAW7]    = waw1 || waw2;
    inc[C_RAW13D1] = raw1;
    inc[C_RAW13D2] = !raw1 && raw2;
    inc[C_RAW13D3] = !raw1 && !raw2 && raw3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      dest_hist  <= '0;
      src_a_hist <= '0;
      src_b_hist <= '0;
      load_hist  <= '0;
      cnt        <= '0;
    end else begin
      if (instr.valid && instr.ready) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end

      if (adv) begin
        out_valid <= 1'b1;
      end else if (counts.ready) begin
        out_valid <= 1'b0;
      end

      if (adv) begin
        dest_hist  <= {dest_hist[HISTORY_DEPTH-2:0], s1_w};
        src_a_hist <= {src_a_hist[HISTORY_DEPTH-2:0], s1_a};
        src_b_hist <= {src_b_hist[HISTORY_DEPTH-2:0], s1_b};
        load_hist  <= {load_hist[HISTORY_DEPTH-2:0], s1_ld};
        for (int k = 0; k < NUM_COUNTERS; k++) begin
          if (inc[k] && (cnt[k] != '1)) begin
            cnt[k] <= cnt[k] + 1'b1;  // saturating
          end
        end
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (instr.valid && instr.ready) begin
      s1_w  <= w_next;
      s1_a  <= a_next;
      s1_b  <= b_next;
      s1_ld <= ld_next;
    end
  end

  assign counts.valid                    = out_valid;
  assign counts.data.raw_5stage          = cnt[C_RAW5];
  assign counts.data.loaduse_5stage      = cnt[C_LU5];
  assign counts.data.waw_5stage          = cnt[C_WAW5];
  assign counts.data.raw_7stage_near     = cnt[C_RAW7N];
  assign counts.data.raw_7stage_far      = cnt[C_RAW7F];
  assign counts.data.loaduse_7stage_near = cnt[C_LU7N];
  assign counts.data.loaduse_7stage_far  = cnt[C_LU7F];
  assign counts.data.waw_7stage          = cnt[C_WAW7];
  assign counts.data.raw_13stage_d1      = cnt[C_RAW13D1];
  assign counts.data.raw_13stage_d2      = cnt[C_RAW13D2];
  assign counts.data.raw_13stage_d3      = cnt[C_RAW13D3];

  // counters move only on a transfer into the output stage
  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(adv) |-> $stable(cnt))
    else $error("counters changed without an item");

  // the distance-one RAW counts of all three pipelines track each other
  a_raw_d1_equal: assert property (@(posedge clk) disable iff (rst)
    (cnt[C_RAW5] == cnt[C_RAW7N]) && (cnt[C_RAW5] == cnt[C_RAW13D1]))
    else $error("distance-one RAW counters disagree");

  a_lu_d1_equal: assert property (@(posedge clk) disable iff (rst)
    cnt[C_LU5] == cnt[C_LU7N])
    else $error("distance-one load-use counters disagree");

  // a RAW is charged to one distance only in the 13-stage set
  a_raw13_one: assert property (@(posedge clk) disable iff (rst)
    adv |-> $onehot0({inc[C_RAW13D1], inc[C_RAW13D2], inc[C_RAW13D3]}))
    else $error("RAW charged to more than one distance");

  // waw_7stage and raw_13stage_d3 never fall outside reset
  a_cnt_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (cnt[C_WAW7] >= $past(cnt[C_WAW7])) &&
                    (cnt[C_RAW13D3] >= $past(cnt[C_RAW13D3])))
    else $error("counter decreased");

endmodule

/* dv/phc_hazard_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phc_hazard_monitor
// Watches both channels of the hazard counter. Every instruction transfer is
// run through a local model of the register histories and the eleven
// saturating counters, and the snapshot it predicts is queued. Every counts
// transfer is compared counter by counter with the oldest queued snapshot.
// ----------------------------------------------------------------------------
module phc_hazard_monitor import phc_pkg::*; (
  input  logic clk,
  input  logic rst,
  phc_in_if    instr,
  phc_out_if   counts,
  input  logic finish_check,
  output int   pending,
  output int   fail_count
);

  // counter 0 (raw_5stage) sits in the top slot, as in counts_t
  typedef logic [NUM_COUNTERS-1:0][CNT_W-1:0] count_vec_t;

  localparam int MAX_PRINTS = 40;

  logic [REG_W-1:0] dest_hist  [HISTORY_DEPTH];
  logic [REG_W-1:0] load_hist  [HISTORY_DEPTH];
  logic [CNT_W-1:0] hazard_cnt [NUM_COUNTERS];
  count_vec_t       expected_counts [$];
  bit               leftovers_checked;

  string counter_name [NUM_COUNTERS] = '{
    "raw_5stage", "loaduse_5stage", "waw_5stage", "raw_7stage_near",
    "raw_7stage_far", "loaduse_7stage_near", "loaduse_7stage_far", "waw_7stage",
    "raw_13stage_d1", "raw_13stage_d2", "raw_13stage_d3"
  };

  task automatic flag(input string msg);
    if (fail_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s", $time, msg);
    fail_count++;
  endtask

  // register zero never matches
  function automatic logic reg_match(input logic [REG_W-1:0] v,
                                     input logic [REG_W-1:0] h);
    return (v != '0) && (v == h);
  endfunction

  function automatic void bump(input int idx);
    if (hazard_cnt[idx] != '1)
      hazard_cnt[idx]++;
  endfunction

  function automatic count_vec_t predict_counts(input instr_t ins);
    logic [REG_W-1:0] w, a, b, ld;
    logic             raw1, raw2, raw3, lu1, lu2;
    count_vec_t       snap;
    w  = '0;
    a  = '0;
    b  = '0;
    ld = '0;
    case (ins.kind)
      KIND_R: begin
        w = ins.dest_reg;
        a = ins.src_reg_a;
        b = ins.src_reg_b;
      end
      KIND_I: begin
        w = ins.src_reg_b;
        a = ins.src_reg_a;
      end
      KIND_LOAD: begin
        w  = ins.src_reg_b;
        a  = ins.src_reg_a;
        ld = ins.src_reg_b;
      end
      default: ;
    endcase

    for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
      dest_hist[i] = dest_hist[i-1];
      load_hist[i] = load_hist[i-1];
    end
    dest_hist[0] = w;
    load_hist[0] = ld;

    raw1 = reg_match(a, dest_hist[1]) || reg_match(b, dest_hist[1]);
    raw2 = reg_match(a, dest_hist[2]) || reg_match(b, dest_hist[2]);
    raw3 = reg_match(a, dest_hist[3]) || reg_match(b, dest_hist[3]);
    lu1  = reg_match(a, load_hist[1]) || reg_match(b, load_hist[1]);
    lu2  = reg_match(a, load_hist[2]) || reg_match(b, load_hist[2]);

    if (raw1) bump(C_RAW5);
    if (lu1) bump(C_LU5);
    if (reg_match(w, dest_hist[1])) bump(C_WAW5);

    if (raw1) bump(C_RAW7N);
    else if (raw2) bump(C_RAW7F);
    if (lu1) bump(C_LU7N);
    else if (lu2) bump(C_LU7F);
    if (reg_match(w, dest_hist[1]) || reg_match(w, dest_hist[2])) bump(C_WAW7);

    if (raw1) bump(C_RAW13D1);
    else if (raw2) bump(C_RAW13D2);
    else if (raw3) bump(C_RAW13D3);

    for (int k = 0; k < NUM_COUNTERS; k++)
      snap[NUM_COUNTERS-1-k] = hazard_cnt[k];
    return snap;
  endfunction

  always @(posedge clk) begin
    count_vec_t got, want;
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        dest_hist[i] = '0;
        load_hist[i] = '0;
      end
      for (int k = 0; k < NUM_COUNTERS; k++)
        hazard_cnt[k] = '0;
      expected_counts.delete();
      leftovers_checked = 1'b0;
      pending = 0;
    end else begin
      // compare before queueing so an early snapshot cannot hide behind a new one
      if (counts.valid && counts.ready) begin
        got = counts.data;
        if (expected_counts.size() == 0) begin
          flag("counts transfer with no snapshot expected");
        end else begin
          want = expected_counts.pop_front();
          for (int k = 0; k < NUM_COUNTERS; k++)
            if (got[NUM_COUNTERS-1-k] !== want[NUM_COUNTERS-1-k])
              flag($sformatf("%s: got %0d, expected %0d", counter_name[k],
                             got[NUM_COUNTERS-1-k], want[NUM_COUNTERS-1-k]));
        end
      end
      if (instr.valid && instr.ready)
        expected_counts.push_back(predict_counts(instr.data));
      if (finish_check && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_counts.size() != 0)
          flag($sformatf("%0d expected snapshots never arrived", expected_counts.size()));
      end
      pending = expected_counts.size();
    end
  end

endmodule

/* dv/tb_pipeline_hazard_counter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pipeline_hazard_counter
// Drives decoded instructions into the hazard counter and takes its counter
// snapshots: a directed sequence of hazard patterns at each distance, then
// random streams over a small register pool under changing idle rates, a
// long output stall and pauses until the output drains.
// ----------------------------------------------------------------------------
module tb_pipeline_hazard_counter;
  import phc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 8;
  localparam int PHASE_ITEMS  = 460;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 10;
  localparam int LIMIT_CYCLES = 200_000;

  localparam logic [KIND_W-1:0] ALL_KINDS [4] = '{KIND_R, KIND_I, KIND_J, KIND_LOAD};

  logic clk;
  logic rst;
  logic finish_check;
  int   pending;
  int   fail_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_reqs;

  phc_in_if  instr_ch ();
  phc_out_if counts_ch ();

  pipeline_hazard_counter dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .counts (counts_ch)
  );

  phc_hazard_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .instr        (instr_ch),
    .counts       (counts_ch),
    .finish_check (finish_check),
    .pending      (pending),
    .fail_count   (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("TEST FAILED");
    $finish;
  end

  // counts receiver: random stalls, or a long hold-off when a new request shows up
  initial begin : recv_proc
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    counts_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_reqs;
      end
      if (rst) begin
        counts_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        counts_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        counts_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // valid stays high after a transfer unless the next call idles or drains
  task automatic send_instr(input instr_t x);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid <= 1'b1;
    instr_ch.data  <= x;
    do @(posedge clk); while (!instr_ch.ready);
  endtask

  task automatic put(input logic [KIND_W-1:0] k, input int rd, input int rs, input int rt);
    instr_t x;
    x.kind      = k;
    x.dest_reg  = REG_W'(rd);
    x.src_reg_a = REG_W'(rs);
    x.src_reg_b = REG_W'(rt);
    send_instr(x);
  endtask

  task automatic drain();
    instr_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // a small pool keeps hazards frequent; the full range toggles every bit
  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(9) < 7)
      return REG_W'($urandom_range(7));
    return REG_W'($urandom_range(31));
  endfunction

  function automatic instr_t rand_instr();
    instr_t x;
    x.kind      = ALL_KINDS[$urandom_range(3)];
    x.dest_reg  = pick_reg();
    x.src_reg_a = pick_reg();
    x.src_reg_b = pick_reg();
    return x;
  endfunction

  initial begin : stim
    rst             <= 1'b1;
    finish_check    <= 1'b0;
    instr_ch.valid  <= 1'b0;
    instr_ch.data   <= '0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 14;
    recv_idle_pct = 49;
    put(KIND_R,     1,  2,  3);
    put(KIND_R,     4,  1,  0);   // RAW distance 1, rt is r0
    put(KIND_I,     0,  1,  5);   // RAW distance 2
    put(KIND_J,    31, 31, 31);   // fields ignored
    put(KIND_R,     6,  5,  4);   // r5 distance 2, r4 distance 3
    put(KIND_LOAD, 31,  0,  7);
    put(KIND_R,     8,  7,  7);   // load-use distance 1
    put(KIND_I,    31, 31,  9);
    put(KIND_R,    10,  9,  7);   // RAW d1; the r7 load is at distance 3, so no load-use
    put(KIND_R,     0,  0,  0);
    put(KIND_R,     0,  0,  0);   // r0 never counts as WAW
    put(KIND_R,    31, 31, 31);
    put(KIND_R,    31, 31, 31);   // WAW and RAW on r31
    put(KIND_I,    31,  0, 31);
    put(KIND_LOAD,  0, 31, 31);
    put(KIND_LOAD,  0, 31, 12);
    put(KIND_J,     0,  0,  0);
    put(KIND_R,     1, 12, 12);   // load-use only at distance 2
    put(KIND_I,     0,  0, 20);
    put(KIND_J,     0,  0,  0);
    put(KIND_J,     0,  0,  0);
    put(KIND_R,    21, 20,  0);   // RAW only at distance 3
    put(KIND_I,    21,  0, 21);   // WAW distance 1
    drain();

    // long output stall while input stays busy, so the block backs up
    send_idle_pct = 0;
    hold_reqs++;
    repeat (30) send_instr(rand_instr());
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 14;
          recv_idle_pct = 49;
        end
        1: begin
          send_idle_pct = 49;
          recv_idle_pct = 14;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_instr(rand_instr());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    finish_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
